### hdl/nbge_pkg.sv
// nbge_pkg: shared types and constants for the n-body euler step core
// payload words, config register indexes, sequencer states, unit control structs
// no dependencies
package nbge_pkg;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // config register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BODY_COUNT = 1'b1;
  localparam logic [31:0] TIME_STEP_RESET  = 32'd4294967;
  localparam logic [6:0]  BODY_COUNT_RESET = 7'd3;

  // body store slots
  localparam int NUM_STORES = 7;
  localparam int SI_POS_X = 0;
  localparam int SI_POS_Y = 1;
  localparam int SI_POS_Z = 2;
  localparam int SI_VEL_X = 3;
  localparam int SI_VEL_Y = 4;
  localparam int SI_VEL_Z = 5;
  localparam int SI_MASS  = 6;

  // multiply issue counts (last issue index)
  localparam logic [3:0] SQ_LAST   = 4'd11;
  localparam logic [3:0] PROD_LAST = 4'd2;
  localparam logic [3:0] POS_LAST  = 4'd1;

  // divide / square root step counts (last step index)
  localparam logic [6:0] DIV_LAST  = 7'd127;
  localparam logic [6:0] SQRT_LAST = 7'd63;

  localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic               command;
    logic [5:0]         body_index;
    logic signed [63:0] pos_x_in;
    logic signed [63:0] pos_y_in;
    logic signed [63:0] pos_z_in;
    logic signed [63:0] vel_x_in;
    logic signed [63:0] vel_y_in;
    logic signed [63:0] vel_z_in;
    logic [63:0]        mass_in;
  } cmd_word_t;

  typedef struct packed {
    logic signed [63:0] next_pos_x;
    logic signed [63:0] next_pos_y;
    logic signed [63:0] next_pos_z;
    logic signed [63:0] next_vel_x;
    logic signed [63:0] next_vel_y;
    logic signed [63:0] next_vel_z;
    logic               singular_pair;
    logic               overflowed;
  } res_word_t;

  typedef enum logic {
    DS_DIV,
    DS_SQRT
  } ds_op_t;

  typedef struct packed {
    logic   start;
    ds_op_t op;
  } ds_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ds_stat_t;

  typedef struct packed {
    logic       clear;
    logic       issue;
    logic [1:0] sh;
  } mac_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LATCH_I,
    ST_NEXT_J,
    ST_DIFF,
    ST_SQ,
    ST_SQ_DRAIN,
    ST_SQRT,
    ST_SQRT_WAIT,
    ST_DIV1,
    ST_DIV1_WAIT,
    ST_DIV2,
    ST_DIV2_WAIT,
    ST_DIVU,
    ST_DIVU_WAIT,
    ST_TSEL,
    ST_PROD,
    ST_PROD_DRAIN,
    ST_PROD_TAKE,
    ST_TACC,
    ST_FIN_PM,
    ST_FIN_PM_DRAIN,
    ST_FIN_PS,
    ST_FIN_VM,
    ST_FIN_VM_DRAIN,
    ST_FIN_VS,
    ST_OUT
  } state_t;

endpackage

### hdl/nbge_ram.sv
// nbge_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module nbge_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/nbge_mac.sv
// nbge_mac: shared 33x33 multiplier with registered product and chunk-shifted accumulator
// depends on nbge_pkg
module nbge_mac (
  input  logic              clk,
  input  logic              rst,
  input  nbge_pkg::mac_req_t req,
  input  logic [32:0]       a,
  input  logic [32:0]       b,
  output logic [129:0]      acc
);
  import nbge_pkg::*;

  logic [65:0] prod;
  logic [1:0]  prod_sh;
  logic        prod_valid;

  // multiply stage
  always_ff @(posedge clk) begin
    prod    <= a * b;
    prod_sh <= req.sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= req.issue;
    end
  end

  // accumulate stage, product placed at a 32-bit chunk boundary
  always_ff @(posedge clk) begin
    if (req.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + (130'(prod) << {prod_sh, 5'b0});
    end
  end

endmodule

### hdl/nbge_divsqrt.sv
// nbge_divsqrt: shared restoring divider (128 by 64) and integer square root (128 bits)
// one quotient or root bit per cycle; depends on nbge_pkg
module nbge_divsqrt (
  input  logic               clk,
  input  logic               rst,
  input  nbge_pkg::ds_req_t  req,
  input  logic [127:0]       num,
  input  logic [63:0]        den,
  output nbge_pkg::ds_stat_t stat,
  output logic [127:0]       quo
);
  import nbge_pkg::*;

  logic         run;
  logic         done;
  ds_op_t       op;
  logic [6:0]   cnt;
  logic [127:0] n, n_next;
  logic [65:0]  rem, rem_next;
  logic [127:0] q_next;
  logic [63:0]  d;
  logic [64:0]  dsh;
  logic [67:0]  ssh;
  logic [67:0]  trial;
  logic         ge;
  logic [6:0]   last;

  assign last = (op == DS_SQRT) ? SQRT_LAST : DIV_LAST;
  assign stat.busy = run;
  assign stat.done = done;

  // one step of divide or square root
  always_comb begin
    dsh   = {rem[63:0], n[127]};
    ssh   = {rem, n[127:126]};
    trial = {2'b00, quo[63:0], 2'b01};
    if (op == DS_SQRT) begin
      ge       = ssh >= trial;
      rem_next = ge ? 66'(ssh - trial) : 66'(ssh);
      n_next   = {n[125:0], 2'b00};
    end else begin
      ge       = dsh >= {1'b0, d};
      rem_next = ge ? 66'(dsh - {1'b0, d}) : 66'(dsh);
      n_next   = {n[126:0], 1'b0};
    end
    q_next = {quo[126:0], ge};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 7'd1;
        if (cnt == last) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      op  <= req.op;
      n   <= num;
      d   <= den;
      rem <= '0;
      quo <= '0;
    end else if (run) begin
      n   <= n_next;
      rem <= rem_next;
      quo <= q_next;
    end
  end

endmodule

### hdl/nbody_gravity_euler_step_core.sv
// n-body gravity euler step core: body stores, sequencer and final scaling.
// a load is written when the word is taken, and a new word can be taken in the next cycle.
// a step is dominated by the one-bit-per-cycle divide/square-root unit, with five divides and
// one root for each non-coincident pair of the stepped body with another body in the sum.
// synchronous reset restores time_step and body_count defaults; stores are undefined.
module nbody_gravity_euler_step_core #(
  parameter int MAX_BODIES = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  output logic                                 cmd_stall,
  input  nbge_pkg::cmd_word_t                  cmd_word,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output nbge_pkg::res_word_t                  res_word,
  input  logic                                 cfg_write,
  input  logic [nbge_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_data
);
  import nbge_pkg::*;

  localparam int AW    = $clog2(MAX_BODIES);
  localparam int CW    = $clog2(MAX_BODIES + 1);
  localparam int IW    = (CW > 6) ? CW : 6;
  localparam int BW    = (CW > 7) ? CW : 7;
  localparam int ACC_W = 65 + AW;
  localparam int NCH   = (ACC_W - 1 + 31) / 32;
  localparam int VW    = ACC_W + 2;
  localparam logic [3:0] VEL_LAST = 4'(NCH - 1);

  state_t state, state_next;

  logic [31:0]      time_step;
  logic [6:0]       body_count;
  logic [AW-1:0]    idx;
  logic [CW-1:0]    count;
  logic [CW-1:0]    j;
  logic [1:0]       ax;
  logic [3:0]       cnt;
  logic [63:0]      pi [3];
  logic [63:0]      vi [3];
  logic [63:0]      mass;
  logic [63:0]      mag [3];
  logic             neg_d [3];
  logic             big;
  logic [63:0]      rroot;
  logic [127:0]     qv;
  logic [32:0]      u;
  logic [63:0]      cterm;
  logic [ACC_W-1:0] tacc [3];
  logic             sing;
  logic             ov;
  logic [63:0]      fpos [3];
  logic [63:0]      fvel [3];

  // store ports
  logic [63:0]   st_wdata [NUM_STORES];
  logic [63:0]   st_rdata [NUM_STORES];
  logic          st_we;
  logic [AW-1:0] ram_raddr;

  // command decode
  logic [IW-1:0] idx_ext;
  logic          idx_ok;
  logic [AW-1:0] cmd_addr;
  logic          cmd_take;
  logic          step_take;
  logic [BW-1:0] bc_ext;
  logic [CW-1:0] count_new;

  // shared units
  ds_req_t      ds_req;
  ds_stat_t     ds_stat;
  logic [127:0] ds_num;
  logic [127:0] ds_quo;
  mac_req_t     mac_req;
  logic [32:0]  mac_a;
  logic [32:0]  mac_b;
  logic [129:0] mac_acc;

  // pair difference
  logic [63:0] d_mag [3];
  logic        d_neg [3];
  logic        big_now;
  logic        zero_now;

  // final sums
  logic [63:0]      vmag;
  logic             vneg;
  logic [64:0]      pscaled;
  logic [65:0]      pos_sum;
  logic             pos_fit;
  logic [ACC_W-1:0] amag;
  logic             aneg;
  logic [NCH*32-1:0] amag_ext;
  logic [ACC_W:0]   vscaled;
  logic [VW-1:0]    vel_sum;
  logic             vel_fit;
  logic             clampq;
  logic             load_out;
  logic             j_is_i;

  assign idx_ext   = IW'(cmd_word.body_index);
  assign idx_ok    = idx_ext < IW'(MAX_BODIES);
  assign cmd_addr  = idx_ext[AW-1:0];
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign step_take = cmd_take && (cmd_word.command == CMD_STEP) && idx_ok;
  assign st_we     = cmd_take && (cmd_word.command == CMD_LOAD) && idx_ok;
  assign bc_ext    = BW'(body_count);
  assign count_new = (bc_ext > BW'(MAX_BODIES)) ? CW'(MAX_BODIES) : CW'(bc_ext);
  assign cmd_stall = (state != ST_IDLE);
  assign clampq    = |qv[127:96];
  assign j_is_i    = (j == CW'(idx));

  assign st_wdata[SI_POS_X] = cmd_word.pos_x_in;
  assign st_wdata[SI_POS_Y] = cmd_word.pos_y_in;
  assign st_wdata[SI_POS_Z] = cmd_word.pos_z_in;
  assign st_wdata[SI_VEL_X] = cmd_word.vel_x_in;
  assign st_wdata[SI_VEL_Y] = cmd_word.vel_y_in;
  assign st_wdata[SI_VEL_Z] = cmd_word.vel_z_in;
  assign st_wdata[SI_MASS]  = cmd_word.mass_in;

  // body stores
  for (genvar g = 0; g < NUM_STORES; g++) begin : g_store
    nbge_ram #(
      .WIDTH(64),
      .DEPTH(MAX_BODIES)
    ) u_store (
      .clk  (clk),
      .we   (st_we),
      .waddr(cmd_addr),
      .wdata(st_wdata[g]),
      .raddr(ram_raddr),
      .rdata(st_rdata[g])
    );
  end

  nbge_divsqrt u_divsqrt (
    .clk (clk),
    .rst (rst),
    .req (ds_req),
    .num (ds_num),
    .den (rroot),
    .stat(ds_stat),
    .quo (ds_quo)
  );

  nbge_mac u_mac (
    .clk(clk),
    .rst(rst),
    .req(mac_req),
    .a  (mac_a),
    .b  (mac_b),
    .acc(mac_acc)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step  <= TIME_STEP_RESET;
      body_count <= BODY_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TIME_STEP:  time_step  <= cfg_data;
        CFG_BODY_COUNT: body_count <= cfg_data[6:0];
        default:        ;
      endcase
    end
  end

  // pair difference, sign and magnitude per axis
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      d_neg[a] = $signed(st_rdata[a]) < $signed(pi[a]);
      d_mag[a] = d_neg[a] ? (pi[a] - st_rdata[a]) : (st_rdata[a] - pi[a]);
    end
    big_now  = d_mag[0][63] | d_mag[1][63] | d_mag[2][63];
    zero_now = (d_mag[0] == '0) && (d_mag[1] == '0) && (d_mag[2] == '0);
  end

  // final position and velocity sums with saturation check
  always_comb begin
    vneg     = vi[ax][63];
    vmag     = vneg ? (~vi[ax] + 64'd1) : vi[ax];
    pscaled  = vneg ? (65'd0 - {1'b0, mac_acc[95:32]}) : {1'b0, mac_acc[95:32]};
    pos_sum  = {{2{pi[ax][63]}}, pi[ax]} + {pscaled[64], pscaled};
    pos_fit  = (pos_sum[65:63] == 3'b000) || (pos_sum[65:63] == 3'b111);
    aneg     = tacc[ax][ACC_W-1];
    amag     = aneg ? (ACC_W'(0) - tacc[ax]) : tacc[ax];
    amag_ext = (NCH*32)'(amag);
    vscaled  = aneg ? ((ACC_W+1)'(0) - {1'b0, mac_acc[ACC_W+31:32]})
                    : {1'b0, mac_acc[ACC_W+31:32]};
    vel_sum  = VW'($signed(vi[ax])) + VW'($signed(vscaled));
    vel_fit  = (&vel_sum[VW-1:63]) || (~|vel_sum[VW-1:63]);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and unit control
  always_comb begin
    state_next = state;
    ram_raddr  = j[AW-1:0];
    ds_req     = '0;
    ds_num     = '0;
    mac_req    = '0;
    mac_a      = '0;
    mac_b      = '0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        ram_raddr = cmd_addr;
        if (step_take) begin
          state_next = ST_LATCH_I;
        end
      end
      ST_LATCH_I: state_next = ST_NEXT_J;
      ST_NEXT_J: begin
        if (j >= count) begin
          state_next = ST_FIN_PM;
        end else if (!j_is_i) begin
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: state_next = zero_now ? ST_NEXT_J : ST_SQ;
      // sum of squares from 32-bit halves
      ST_SQ: begin
        mac_req.issue = 1'b1;
        mac_req.clear = (cnt == '0);
        mac_req.sh    = {1'b0, cnt[1]} + {1'b0, cnt[0]};
        mac_a = {1'b0, cnt[1] ? mag[cnt[3:2]][63:32] : mag[cnt[3:2]][31:0]};
        mac_b = {1'b0, cnt[0] ? mag[cnt[3:2]][63:32] : mag[cnt[3:2]][31:0]};
        if (cnt == SQ_LAST) begin
          state_next = ST_SQ_DRAIN;
        end
      end
      ST_SQ_DRAIN: state_next = ST_SQRT;
      ST_SQRT: begin
        ds_req.start = 1'b1;
        ds_req.op    = DS_SQRT;
        ds_num       = mac_acc[127:0];
        state_next   = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: if (ds_stat.done) state_next = ST_DIV1;
      ST_DIV1: begin
        ds_req.start = 1'b1;
        ds_req.op    = DS_DIV;
        ds_num       = {32'd0, mass, 32'd0};
        state_next   = ST_DIV1_WAIT;
      end
      ST_DIV1_WAIT: if (ds_stat.done) state_next = ST_DIV2;
      ST_DIV2: begin
        ds_req.start = 1'b1;
        ds_req.op    = DS_DIV;
        ds_num       = {qv[95:0], 32'd0};
        state_next   = ST_DIV2_WAIT;
      end
      ST_DIV2_WAIT: if (ds_stat.done) state_next = ST_DIVU;
      ST_DIVU: begin
        ds_req.start = 1'b1;
        ds_req.op    = DS_DIV;
        ds_num       = {32'd0, mag[ax], 32'd0};
        state_next   = ST_DIVU_WAIT;
      end
      ST_DIVU_WAIT: if (ds_stat.done) state_next = ST_TSEL;
      ST_TSEL: state_next = ((u == '0) || clampq) ? ST_TACC : ST_PROD;
      // term magnitude q*u in 32-bit chunks of q
      ST_PROD: begin
        mac_req.issue = 1'b1;
        mac_req.clear = (cnt == '0);
        mac_req.sh    = cnt[1:0];
        mac_a = {1'b0, qv[32*cnt[1:0] +: 32]};
        mac_b = u;
        if (cnt == PROD_LAST) begin
          state_next = ST_PROD_DRAIN;
        end
      end
      ST_PROD_DRAIN: state_next = ST_PROD_TAKE;
      ST_PROD_TAKE:  state_next = ST_TACC;
      ST_TACC:       state_next = (ax == 2'd2) ? ST_NEXT_J : ST_DIVU;
      // velocity times dt for the position
      ST_FIN_PM: begin
        mac_req.issue = 1'b1;
        mac_req.clear = (cnt == '0);
        mac_req.sh    = {1'b0, cnt[0]};
        mac_a = {1'b0, vmag[32*cnt[0] +: 32]};
        mac_b = {1'b0, time_step};
        if (cnt == POS_LAST) begin
          state_next = ST_FIN_PM_DRAIN;
        end
      end
      ST_FIN_PM_DRAIN: state_next = ST_FIN_PS;
      ST_FIN_PS:       state_next = ST_FIN_VM;
      // force sum times dt for the velocity
      ST_FIN_VM: begin
        mac_req.issue = 1'b1;
        mac_req.clear = (cnt == '0);
        mac_req.sh    = cnt[1:0];
        mac_a = {1'b0, amag_ext[32*cnt[1:0] +: 32]};
        mac_b = {1'b0, time_step};
        if (cnt == VEL_LAST) begin
          state_next = ST_FIN_VM_DRAIN;
        end
      end
      ST_FIN_VM_DRAIN: state_next = ST_FIN_VS;
      ST_FIN_VS:       state_next = (ax == 2'd2) ? ST_OUT : ST_FIN_PM;
      ST_OUT: begin
        if (!res_valid || !res_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // issue counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (mac_req.issue) begin
      cnt <= cnt + 4'd1;
    end else begin
      cnt <= '0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (step_take) begin
          idx   <= cmd_addr;
          count <= count_new;
        end
      end
      ST_LATCH_I: begin
        for (int a = 0; a < 3; a++) begin
          pi[a]   <= st_rdata[a];
          vi[a]   <= st_rdata[3+a];
          tacc[a] <= '0;
        end
        sing <= 1'b0;
        ov   <= 1'b0;
        j    <= '0;
      end
      ST_NEXT_J: begin
        ax <= '0;
        if (j < count && j_is_i) begin
          j <= j + CW'(1);
        end
      end
      ST_DIFF: begin
        mass <= st_rdata[SI_MASS];
        big  <= big_now;
        for (int a = 0; a < 3; a++) begin
          mag[a]   <= big_now ? (d_mag[a] >> 1) : d_mag[a];
          neg_d[a] <= d_neg[a];
        end
        if (zero_now) begin
          sing <= 1'b1;
          j    <= j + CW'(1);
        end
      end
      ST_SQRT_WAIT: if (ds_stat.done) rroot <= ds_quo[63:0];
      ST_DIV1_WAIT: if (ds_stat.done) qv <= ds_quo;
      ST_DIV2_WAIT: if (ds_stat.done) qv <= big ? (ds_quo >> 2) : ds_quo;
      ST_DIVU_WAIT: if (ds_stat.done) u <= ds_quo[32:0];
      ST_TSEL: begin
        if (u == '0) begin
          cterm <= '0;
        end else if (clampq) begin
          cterm <= '1;
          ov    <= 1'b1;
        end
      end
      ST_PROD_TAKE: begin
        if (|mac_acc[129:96]) begin
          cterm <= '1;
          ov    <= 1'b1;
        end else begin
          cterm <= mac_acc[95:32];
        end
      end
      ST_TACC: begin
        tacc[ax] <= tacc[ax] + (neg_d[ax] ? (ACC_W'(0) - ACC_W'(cterm)) : ACC_W'(cterm));
        if (ax == 2'd2) begin
          j <= j + CW'(1);
        end else begin
          ax <= ax + 2'd1;
        end
      end
      ST_FIN_PS: begin
        fpos[ax] <= pos_fit ? pos_sum[63:0] : (pos_sum[65] ? SAT_MIN : SAT_MAX);
        if (!pos_fit) ov <= 1'b1;
      end
      ST_FIN_VS: begin
        fvel[ax] <= vel_fit ? vel_sum[63:0] : (vel_sum[VW-1] ? SAT_MIN : SAT_MAX);
        if (!vel_fit) ov <= 1'b1;
        if (ax != 2'd2) ax <= ax + 2'd1;
      end
      default: ;
    endcase
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_word.next_pos_x    <= fpos[0];
      res_word.next_pos_y    <= fpos[1];
      res_word.next_pos_z    <= fpos[2];
      res_word.next_vel_x    <= fvel[0];
      res_word.next_vel_y    <= fvel[1];
      res_word.next_vel_z    <= fvel[2];
      res_word.singular_pair <= sing;
      res_word.overflowed    <= ov;
    end
  end

  // divide unit is never restarted mid run
  a_ds_start_idle: assert property (@(posedge clk) disable iff (rst)
    ds_req.start |-> !ds_stat.busy)
    else $error("divide/sqrt started while busy");

  // a finished divide or root always lands in a wait state
  a_ds_done_wait: assert property (@(posedge clk) disable iff (rst)
    ds_stat.done |-> (state == ST_SQRT_WAIT || state == ST_DIV1_WAIT ||
                      state == ST_DIV2_WAIT || state == ST_DIVU_WAIT))
    else $error("divide/sqrt result with no consumer");

  // a pair is only formed with a body inside the sum and never with itself
  a_pair_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIFF |-> (j < count && !j_is_i))
    else $error("pair index out of range");

  // the shared units are quiet while waiting for a new word
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> (!ds_stat.busy && !mac_req.issue))
    else $error("shared unit active in idle");

endmodule

### test/tb_nbody_gravity_euler_step_core.sv
// testbench for nbody_gravity_euler_step_core: loads bodies, steps them, checks every result word
// depends on nbge_pkg and the core; a class keeps a bit-exact predictor and the expected words
module tb_nbody_gravity_euler_step_core;
  import nbge_pkg::*;

  // body store mirror, force-sum predictor and queue of expected result words
  class euler_ledger;
    logic [63:0] pos [3][64];
    logic [63:0] vel [3][64];
    logic [63:0] mass [64];
    logic [31:0] dt_frac;
    logic [6:0]  bodies;
    res_word_t   want_q[$];
    int          mismatches;

    function new();
      dt_frac = TIME_STEP_RESET;
      bodies = BODY_COUNT_RESET;
      mismatches = 0;
      // mirror starts at zero so a copied slot always holds defined data
      for (int k = 0; k < 64; k++) begin
        mass[k] = '0;
        for (int a = 0; a < 3; a++) begin
          pos[a][k] = '0;
          vel[a][k] = '0;
        end
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      if (idx == CFG_TIME_STEP) dt_frac = data;
      else bodies = data[6:0];
    endfunction

    function logic [63:0] isqrt(logic [127:0] s);
      logic [63:0] r, c;
      logic [127:0] cc;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (64'd1 << b);
        cc = {64'd0, c} * {64'd0, c};
        if (cc <= s) r = c;
      end
      return r;
    endfunction

    // dt scaling truncates the magnitude toward zero
    function logic [127:0] scale_dt(logic [127:0] v);
      logic [127:0] m;
      logic [159:0] p;
      m = v[127] ? -v : v;
      p = {32'd0, m} * {128'd0, dt_frac};
      return v[127] ? -p[159:32] : p[159:32];
    endfunction

    function logic [63:0] clip64(logic [127:0] v, inout logic ov);
      if (v[127:63] == '0 || v[127:63] == '1) return v[63:0];
      ov = 1'b1;
      return v[127] ? SAT_MIN : SAT_MAX;
    endfunction

    function res_word_t gravity_step(int i);
      res_word_t   res;
      logic [127:0] acc [3];
      logic [63:0] mag [3];
      logic        neg [3];
      logic        big, sing, ov, clampq;
      logic [127:0] s, q, num;
      logic [63:0] r, u, c;
      logic [159:0] prod;
      int          cnt;
      logic [127:0] npos [3];
      logic [127:0] nvel [3];
      sing = 0;
      ov = 0;
      for (int a = 0; a < 3; a++) acc[a] = 0;
      cnt = bodies > 64 ? 64 : bodies;
      for (int j = 0; j < cnt; j++) begin
        if (j == i) continue;
        big = 0;
        for (int a = 0; a < 3; a++) begin
          neg[a] = $signed(pos[a][j]) < $signed(pos[a][i]);
          mag[a] = neg[a] ? pos[a][i] - pos[a][j] : pos[a][j] - pos[a][i];
          if (mag[a][63]) big = 1;
        end
        // coincident pair is skipped
        if (mag[0] == 0 && mag[1] == 0 && mag[2] == 0) begin
          sing = 1;
          continue;
        end
        s = 0;
        for (int a = 0; a < 3; a++) begin
          if (big) mag[a] = mag[a] >> 1;
          s = s + {64'd0, mag[a]} * {64'd0, mag[a]};
        end
        r = isqrt(s);
        num = {32'd0, mass[j], 32'd0};
        q = num / {64'd0, r};
        q = {q[95:0], 32'd0} / {64'd0, r};
        if (big) q = q >> 2;
        clampq = q[127:96] != 0;
        for (int a = 0; a < 3; a++) begin
          num = {32'd0, mag[a], 32'd0} / {64'd0, r};
          u = num[63:0];
          if (u == 0) c = 0;
          else if (clampq) begin
            c = '1;
            ov = 1;
          end else begin
            prod = {32'd0, q} * {96'd0, u};
            if (prod[127:96] != 0) begin
              c = '1;
              ov = 1;
            end else c = prod[95:32];
          end
          acc[a] = acc[a] + (neg[a] ? -{64'd0, c} : {64'd0, c});
        end
      end
      for (int a = 0; a < 3; a++) begin
        npos[a] = {{64{pos[a][i][63]}}, pos[a][i]}
                  + scale_dt({{64{vel[a][i][63]}}, vel[a][i]});
        nvel[a] = {{64{vel[a][i][63]}}, vel[a][i]} + scale_dt(acc[a]);
      end
      res.next_pos_x = clip64(npos[0], ov);
      res.next_vel_x = clip64(nvel[0], ov);
      res.next_pos_y = clip64(npos[1], ov);
      res.next_vel_y = clip64(nvel[1], ov);
      res.next_pos_z = clip64(npos[2], ov);
      res.next_vel_z = clip64(nvel[2], ov);
      res.singular_pair = sing;
      res.overflowed = ov;
      return res;
    endfunction

    function void note_cmd(cmd_word_t w);
      int i;
      i = w.body_index;
      if (w.command == CMD_LOAD) begin
        pos[0][i] = w.pos_x_in;
        pos[1][i] = w.pos_y_in;
        pos[2][i] = w.pos_z_in;
        vel[0][i] = w.vel_x_in;
        vel[1][i] = w.vel_y_in;
        vel[2][i] = w.vel_z_in;
        mass[i] = w.mass_in;
      end else want_q.push_back(gravity_step(i));
    endfunction

    function void check_res(res_word_t got);
      res_word_t want;
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      want = want_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch\n  exp %h\n  got %h", want, got);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cmd_valid = 0;
  logic        cmd_stall;
  cmd_word_t   cmd_word = '0;
  logic        res_valid;
  logic        res_stall = 0;
  res_word_t   res_word;
  logic        cfg_write = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  euler_ledger sb = new();
  int stall_left = 0;

  nbody_gravity_euler_step_core dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_word(cmd_word),
    .res_valid(res_valid), .res_stall(res_stall), .res_word(res_word),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // mostly short idle runs, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side: check accepted words, stall at random
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) sb.check_res(res_word);
      if (stall_left > 0) begin
        stall_left--;
        res_stall <= 1;
      end else begin
        stall_left = pick_gap();
        res_stall <= stall_left > 0;
        if (stall_left > 0) stall_left--;
      end
    end
  end

  task automatic send_word(cmd_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1;
    cmd_word <= w;
    do @(posedge clk); while (cmd_stall);
    sb.note_cmd(w);
  endtask

  // sender pauses until every expected word has come, then lets the core settle
  task automatic drain();
    cmd_valid <= 0;
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    drain();
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 0;
    sb.set_reg(idx, data);
  endtask

  function automatic logic [63:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return {$urandom, $urandom};
    if (r < 8) return {{24{$urandom_range(0, 1) == 1}}, 8'($urandom_range(0, 255)), $urandom};
    case ($urandom_range(0, 4))
      0: return SAT_MAX;
      1: return SAT_MIN;
      2: return 0;
      3: return '1;
      default: return 1;
    endcase
  endfunction

  function automatic logic [63:0] rand_mass();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return 0;
      2, 3: return {$urandom, $urandom};
      default: return {24'd0, 8'($urandom_range(0, 255)), $urandom};
    endcase
  endfunction

  function automatic cmd_word_t load_word(int i);
    cmd_word_t w;
    int k;
    w.command = CMD_LOAD;
    w.body_index = 6'(i);
    w.pos_x_in = rand_coord();
    w.pos_y_in = rand_coord();
    w.pos_z_in = rand_coord();
    w.vel_x_in = rand_coord();
    w.vel_y_in = rand_coord();
    w.vel_z_in = rand_coord();
    w.mass_in = rand_mass();
    // sometimes land on another body to hit the coincident case
    if ($urandom_range(0, 6) == 0) begin
      k = $urandom_range(0, 63);
      w.pos_x_in = sb.pos[0][k];
      w.pos_y_in = sb.pos[1][k];
      w.pos_z_in = sb.pos[2][k];
    end
    return w;
  endfunction

  function automatic cmd_word_t step_word(int i);
    cmd_word_t w;
    logic [479:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    w = noise[$bits(cmd_word_t)-1:0];
    w.command = CMD_STEP;
    w.body_index = 6'(i);
    return w;
  endfunction

  initial begin
    cmd_word_t w;
    int count, nitems;
    logic [31:0] dt_pick;
    repeat (6) @(posedge clk);
    rst <= 0;

    // fill every body slot so no step reads an unwritten entry
    for (int i = 0; i < 64; i++) send_word(load_word(i));

    // directed: coincident pair, huge distance, huge mass, extreme fields
    w = load_word(1);
    w.pos_x_in = sb.pos[0][0];
    w.pos_y_in = sb.pos[1][0];
    w.pos_z_in = sb.pos[2][0];
    send_word(w);
    w = load_word(2);
    w.pos_x_in = SAT_MAX;
    w.vel_x_in = SAT_MAX;
    w.mass_in = '1;
    send_word(w);
    w = load_word(3);
    w.pos_x_in = SAT_MIN;
    w.vel_x_in = SAT_MIN;
    w.mass_in = '1;
    send_word(w);
    w = load_word(63);
    w.pos_y_in = SAT_MIN;
    w.vel_z_in = SAT_MAX;
    w.mass_in = 0;
    send_word(w);
    write_reg(CFG_BODY_COUNT, 4);
    for (int i = 0; i < 4; i++) send_word(step_word(i));
    send_word(step_word(63));
    write_reg(CFG_TIME_STEP, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) send_word(step_word(i));
    write_reg(CFG_TIME_STEP, 0);
    send_word(step_word(2));
    write_reg(CFG_BODY_COUNT, 0);
    send_word(step_word(63));
    write_reg(CFG_TIME_STEP, TIME_STEP_RESET);
    write_reg(CFG_BODY_COUNT, 64);
    send_word(step_word(5));
    write_reg(CFG_BODY_COUNT, 127);
    send_word(step_word(63));

    // random phases: mostly small sums, a few heavy ones
    for (int ph = 0; ph < 20; ph++) begin
      case ($urandom_range(0, 5))
        0: dt_pick = 32'hFFFF_FFFF;
        1: dt_pick = 0;
        2: dt_pick = TIME_STEP_RESET;
        default: dt_pick = $urandom;
      endcase
      write_reg(CFG_TIME_STEP, dt_pick);
      count = (ph % 9 == 8) ? 64 : $urandom_range(1, 4);
      if (ph == 5) count = 0;
      write_reg(CFG_BODY_COUNT, count);
      nitems = 55;
      for (int n = 0; n < nitems; n++) begin
        if ($urandom_range(0, 9) < 6 || (count > 8 && n != 20))
          send_word(load_word($urandom_range(0, 63)));
        else if ($urandom_range(0, 1) == 1)
          send_word(step_word($urandom_range(0, count > 0 ? count - 1 : 0)));
        else
          send_word(step_word($urandom_range(0, 63)));
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.want_q.size() == 0)
      $display("tb_nbody_gravity_euler_step_core: clean");
    else
      $display("tb_nbody_gravity_euler_step_core: errors");
    $finish;
  end

  // watchdog
  initial begin
    #40000000;
    $display("tb_nbody_gravity_euler_step_core: errors");
    $finish;
  end

endmodule
